FILE: design/voxel_ray_traversal_defines.svh
// Assertion macros shared by the voxel ray traversal RTL.
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define VRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define VRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vrt_pkg.sv
// Types and constants shared by the voxel ray traversal modules.
package vrt_pkg;

  localparam int CELL_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF = 12;

  localparam int NUM_AXES    = 3;
  localparam int ORIGIN_W    = 32;
  localparam int DIR_W       = 16;
  localparam int CROSS_W     = 32;
  localparam int QUOT_W      = 31;
  localparam int CELL_OUT_W  = 20;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 64;
  localparam int DIR_OFS     = NUM_AXES * ORIGIN_W;
  localparam int SOLID_BIT   = DIR_OFS + NUM_AXES * DIR_W;
  localparam int PADDR_W     = 3;

  localparam logic [QUOT_W-1:0]  RECIP_DIVIDEND = 31'h4000_0000;
  localparam logic [CROSS_W-1:0] CROSS_SAT      = 32'hFFFF_FFFF;
  localparam logic [31:0]        MAX_REACH_RST  = 32'd327680;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_ANSWER = 1'b1;

  localparam logic REG_MAX_REACH = 1'b0;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_QUERY    = 2'd0,
    ST_HIT      = 2'd1,
    ST_MISS     = 2'd2,
    ST_IDLE_ANS = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_AXIS  = 6'b000100,
    S_DIV   = 6'b001000,
    S_MUL   = 6'b010000,
    S_CROSS = 6'b100000
  } state_e;

endpackage

FILE: design/vrt_div.sv
// Bit-serial restoring divider that forms the reciprocal crossing step.
module vrt_div import vrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIR_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int CntW = $clog2(QUOT_W + 1);

  logic [DIR_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DIR_W-1:0]  dvs_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIR_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quot_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = RECIP_DIVIDEND;
      cnt_d  = CntW'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DIR_W'(trial - {1'b0, dvs_q}) : DIR_W'(trial);
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: design/voxel_ray_traversal.sv
// Top level of the voxel ray traversal: sequencer, axis state and stream ports.
// An answer that hits, or comes while idle, gives its result in the cycle after the transfer.
// An answer that steps goes through S_STEP, which registers its result.
// A start takes each axis in turn through S_AXIS, S_DIV, S_MUL and S_CROSS (only S_AXIS for a zero
// direction component), using the divider that forms one quotient bit per cycle, shared by all three axes.
// rst_ni clears the sequencer and the active ray at once and loads max_reach with 5.0.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_solid, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic                   s_axis_tuser_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // cell_x, cell_y, cell_z, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [PADDR_W-1:0]     paddr_i,
  input  logic [31:0]            pwdata_i,
  output logic [31:0]            prdata_o,
  output logic                   pready_o
);

  `include "voxel_ray_traversal_defines.svh"

  localparam int DistW = FRAC_BITS + 1;
  localparam int ProdW = DistW + QUOT_W;

  state_e                 state_q, state_d;
  axis_t                  axis_q, axis_d;
  axis_t                  sel_q, sel_next;
  logic                   ray_active_q, ray_active_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            max_reach_q;

  logic [CELL_BITS-1:0]   cur_cell_q   [NUM_AXES];
  logic [CROSS_W-1:0]     next_cross_q [NUM_AXES];
  logic [CROSS_W-1:0]     cross_step_q [NUM_AXES];
  logic                   step_neg_q   [NUM_AXES];
  logic [DIR_W-1:0]       mag_q        [NUM_AXES];
  logic [FRAC_BITS-1:0]   frac_q       [NUM_AXES];
  logic [ProdW-1:0]       prod_q;

  logic [CELL_OUT_W-1:0]  out_cell_q   [NUM_AXES];
  status_e                out_status_q;

  logic [ORIGIN_W-1:0]    in_origin    [NUM_AXES];
  logic [DIR_W-1:0]       in_dir       [NUM_AXES];
  logic                   in_req;
  logic                   in_solid;
  logic                   in_fire;

  logic                   div_start;
  logic                   div_done;
  logic [QUOT_W-1:0]      div_quot;

  logic                   emit;
  logic                   emit_zero;
  status_e                emit_status;
  logic [CELL_BITS-1:0]   emit_cell    [NUM_AXES];
  logic [CELL_BITS-1:0]   stepped_cell;
  logic [CROSS_W:0]       cross_sum;
  logic [CROSS_W-1:0]     cross_sat;
  logic                   beyond;
  logic                   mag_zero;
  logic [DistW-1:0]       bnd_dist;
  logic                   cfg_write;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      in_origin[a] = s_axis_tdata_i[a*ORIGIN_W +: ORIGIN_W];
      in_dir[a]    = s_axis_tdata_i[DIR_OFS + a*DIR_W +: DIR_W];
    end
  end
  assign in_req   = s_axis_tuser_i;
  assign in_solid = s_axis_tdata_i[SOLID_BIT];

  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (next_cross_q[AXIS_X] < next_cross_q[AXIS_Y]) begin
      sel_next = (next_cross_q[AXIS_X] < next_cross_q[AXIS_Z]) ? AXIS_X : AXIS_Z;
    end else begin
      sel_next = (next_cross_q[AXIS_Y] < next_cross_q[AXIS_Z]) ? AXIS_Y : AXIS_Z;
    end
  end

  assign stepped_cell = cur_cell_q[sel_q] +
                        (step_neg_q[sel_q] ? {CELL_BITS{1'b1}} : CELL_BITS'(1));
  assign cross_sum    = {1'b0, next_cross_q[sel_q]} + {1'b0, cross_step_q[sel_q]};
  assign cross_sat    = cross_sum[CROSS_W] ? CROSS_SAT : cross_sum[CROSS_W-1:0];
  assign beyond       = next_cross_q[sel_q] > max_reach_q;

  assign mag_zero = mag_q[axis_q] == '0;
  assign bnd_dist = step_neg_q[axis_q] ? {1'b0, frac_q[axis_q]}
                                       : {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_q[axis_q]};

  vrt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (mag_q[axis_q]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    ray_active_d = ray_active_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    div_start    = 1'b0;
    emit         = 1'b0;
    emit_zero    = 1'b0;
    emit_status  = ST_QUERY;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req == REQ_START) begin
            state_d      = S_AXIS;
            axis_d       = AXIS_X;
            ray_active_d = 1'b0;
          end else if (!ray_active_q) begin
            emit        = 1'b1;
            emit_zero   = 1'b1;
            emit_status = ST_IDLE_ANS;
          end else if (in_solid) begin
            emit         = 1'b1;
            emit_status  = ST_HIT;
            ray_active_d = 1'b0;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (beyond) begin
          emit_status  = ST_MISS;
          ray_active_d = 1'b0;
        end
      end
      S_AXIS: begin
        if (mag_zero) begin
          if (axis_q == AXIS_Z) begin
            emit         = 1'b1;
            ray_active_d = 1'b1;
            state_d      = S_IDLE;
          end else begin
            axis_d = axis_q + axis_t'(1);
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CROSS;
      end
      S_CROSS: begin
        if (axis_q == AXIS_Z) begin
          emit         = 1'b1;
          ray_active_d = 1'b1;
          state_d      = S_IDLE;
        end else begin
          axis_d  = axis_q + axis_t'(1);
          state_d = S_AXIS;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      emit_cell[a] = ((state_q == S_STEP) && (sel_q == axis_t'(a))) ? stepped_cell
                                                                     : cur_cell_q[a];
    end
  end

  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o &&
                     (paddr_i[2] == REG_MAX_REACH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= AXIS_X;
      ray_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
      max_reach_q  <= MAX_REACH_RST;
    end else begin
      state_q      <= state_d;
      axis_q       <= axis_d;
      ray_active_q <= ray_active_d;
      out_valid_q  <= out_valid_d;
      if (cfg_write) begin
        max_reach_q <= pwdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_fire) begin
      sel_q <= sel_next;
      if (in_req == REQ_START) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          cur_cell_q[a] <= CELL_BITS'($signed(in_origin[a]) >>> FRAC_BITS);
          frac_q[a]     <= in_origin[a][FRAC_BITS-1:0];
          mag_q[a]      <= in_dir[a][DIR_W-1] ? DIR_W'(-in_dir[a]) : in_dir[a];
          step_neg_q[a] <= (in_dir[a] == '0) || in_dir[a][DIR_W-1];
        end
      end
    end
    if (state_q == S_STEP) begin
      next_cross_q[sel_q] <= cross_sat;
      cur_cell_q[sel_q]   <= stepped_cell;
    end
    if ((state_q == S_AXIS) && mag_zero) begin
      cross_step_q[axis_q] <= CROSS_SAT;
      next_cross_q[axis_q] <= CROSS_SAT;
    end
    if ((state_q == S_DIV) && div_done) begin
      cross_step_q[axis_q] <= CROSS_W'(div_quot);
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(bnd_dist) * ProdW'(cross_step_q[axis_q][QUOT_W-1:0]);
    end
    if (state_q == S_CROSS) begin
      next_cross_q[axis_q] <= prod_q[FRAC_BITS +: CROSS_W];
    end
    if (emit) begin
      out_status_q <= emit_status;
      for (int a = 0; a < NUM_AXES; a++) begin
        out_cell_q[a] <= emit_zero ? '0 : CELL_OUT_W'($signed(emit_cell[a]));
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - NUM_AXES*CELL_OUT_W)'(0),
                            out_cell_q[AXIS_Z], out_cell_q[AXIS_Y], out_cell_q[AXIS_X]};

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_MAX_REACH) ? max_reach_q : '0;

  `VRT_ASSERT_IMP(a_busy_slot_free, state_q != S_IDLE, !out_valid_q, "result pending while busy")
  `VRT_ASSERT_NXT(a_answer_steps, in_fire && (in_req == REQ_ANSWER) && ray_active_q && !in_solid, state_q == S_STEP, "open cell did not step")
  `VRT_ASSERT_NXT(a_start_restarts, in_fire && (in_req == REQ_START), (state_q == S_AXIS) && (axis_q == AXIS_X) && !ray_active_q, "start did not restart the ray")

endmodule

FILE: dv/tb_voxel_ray_traversal.sv
// Self-checking testbench for the voxel ray traversal block, with a stream driver and a checker.
module tb_voxel_ray_traversal;
  import vrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_W        = CELL_BITS_DEF;
  localparam int FRAC_W        = FRAC_BITS_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CELL_OUT_W-1:0] cell_x;
    logic [CELL_OUT_W-1:0] cell_y;
    logic [CELL_OUT_W-1:0] cell_z;
    status_e               status;
  } ray_result_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_solid, zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  // req_type
  logic                   s_axis_tuser_i = REQ_START;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // cell_x, cell_y, cell_z, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // status
  logic [1:0]             m_axis_tuser_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic                   psel_i = 1'b0;
  logic                   penable_i = 1'b0;
  logic                   pwrite_i = 1'b0;
  logic [PADDR_W-1:0]     paddr_i = '0;
  logic [31:0]            pwdata_i = '0;
  logic [31:0]            prdata_o;
  logic                   pready_o;

  voxel_ray_traversal uut (
    .clk_i, .rst_ni,
    .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tvalid_i, .s_axis_tready_o,
    .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tvalid_o, .m_axis_tready_i,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  // Shadow of the walk state.
  logic [CELL_W-1:0]  walk_cell [NUM_AXES] = '{default: '0};
  logic [CROSS_W-1:0] walk_cross [NUM_AXES] = '{default: '0};
  logic [CROSS_W-1:0] walk_stride [NUM_AXES] = '{default: '0};
  bit                 walk_neg [NUM_AXES] = '{default: 1'b0};
  logic [CROSS_W-1:0] walk_dist = '0;
  bit                 walk_live = 1'b0;
  logic [31:0]        reach_cfg = MAX_REACH_RST;

  ray_result_t pending_results[$];
  int          fault_count = 0;
  int          quiet_cycles = 0;
  int          hold_req = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void launch_axis(int a, logic [ORIGIN_W-1:0] o, logic [DIR_W-1:0] dv);
    logic [DIR_W-1:0] mag;
    logic [63:0]      span;
    logic [63:0]      prod;
    walk_cell[a] = CELL_W'($signed(o) >>> FRAC_W);
    walk_neg[a]  = (dv == '0) || dv[DIR_W-1];
    mag = dv[DIR_W-1] ? (~dv + 1'b1) : dv;
    if (mag == '0) begin
      walk_stride[a] = CROSS_SAT;
      walk_cross[a]  = CROSS_SAT;
    end else begin
      walk_stride[a] = CROSS_W'(64'h4000_0000 / 64'(mag));
      span = walk_neg[a] ? 64'(o[FRAC_W-1:0]) : (64'd1 << FRAC_W) - 64'(o[FRAC_W-1:0]);
      prod = (span * 64'(walk_stride[a])) >> FRAC_W;
      walk_cross[a] = (prod > 64'(CROSS_SAT)) ? CROSS_SAT : CROSS_W'(prod);
    end
  endfunction

  function automatic ray_result_t walk_predict(logic kind, logic [IN_TDATA_W-1:0] d);
    ray_result_t res;
    axis_t       ax;
    int          a;
    logic [32:0] sum;
    res = '0;
    if (kind == REQ_START) begin
      for (int i = 0; i < NUM_AXES; i++)
        launch_axis(i, d[i*ORIGIN_W +: ORIGIN_W], d[DIR_OFS + i*DIR_W +: DIR_W]);
      walk_dist = '0;
      walk_live = 1'b1;
      res.status = ST_QUERY;
    end else if (!walk_live) begin
      res.status = ST_IDLE_ANS;
      return res;
    end else if (d[SOLID_BIT]) begin
      walk_live = 1'b0;
      res.status = ST_HIT;
    end else begin
      if (walk_cross[AXIS_X] < walk_cross[AXIS_Y])
        ax = (walk_cross[AXIS_X] < walk_cross[AXIS_Z]) ? AXIS_X : AXIS_Z;
      else
        ax = (walk_cross[AXIS_Y] < walk_cross[AXIS_Z]) ? AXIS_Y : AXIS_Z;
      a = int'(ax);
      walk_dist = walk_cross[a];
      sum = {1'b0, walk_cross[a]} + {1'b0, walk_stride[a]};
      walk_cross[a] = sum[32] ? CROSS_SAT : sum[31:0];
      walk_cell[a] = walk_neg[a] ? walk_cell[a] - 1'b1 : walk_cell[a] + 1'b1;
      if (walk_dist > reach_cfg) begin
        walk_live = 1'b0;
        res.status = ST_MISS;
      end else begin
        res.status = ST_QUERY;
      end
    end
    res.cell_x = CELL_OUT_W'($signed(walk_cell[AXIS_X]));
    res.cell_y = CELL_OUT_W'($signed(walk_cell[AXIS_Y]));
    res.cell_z = CELL_OUT_W'($signed(walk_cell[AXIS_Z]));
    return res;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      fault_count++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] start_item(logic [ORIGIN_W-1:0] ox, oy, oz,
                                                      logic [DIR_W-1:0] dx, dy, dz);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[0 +: ORIGIN_W]                = ox;
    d[ORIGIN_W +: ORIGIN_W]         = oy;
    d[2*ORIGIN_W +: ORIGIN_W]       = oz;
    d[DIR_OFS +: DIR_W]             = dx;
    d[DIR_OFS + DIR_W +: DIR_W]     = dy;
    d[DIR_OFS + 2*DIR_W +: DIR_W]   = dz;
    d[SOLID_BIT]                    = 1'($urandom_range(0, 1));
    return d;
  endfunction

  // The fields that only a start uses carry noise on an answer.
  function automatic logic [IN_TDATA_W-1:0] answer_item(logic solid);
    logic [159:0] raw;
    logic [IN_TDATA_W-1:0] d;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    d = raw[IN_TDATA_W-1:0];
    d[IN_TDATA_W-1:SOLID_BIT] = '0;
    d[SOLID_BIT] = solid;
    return d;
  endfunction

  function automatic logic [ORIGIN_W-1:0] rand_origin();
    if ($urandom_range(0, 99) < 85) return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
    return $urandom();
  endfunction

  function automatic logic [DIR_W-1:0] rand_dir();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] rand_start();
    return start_item(rand_origin(), rand_origin(), rand_origin(),
                      rand_dir(), rand_dir(), rand_dir());
  endfunction

  task automatic send_item(input logic kind, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(walk_predict(kind, data));
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reach(input logic [31:0] v);
    logic [31:0] rd;
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= PADDR_W'({REG_MAX_REACH, 2'b00});
    pwdata_i  <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    reach_cfg = v;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rd = prdata_o;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    check_field("max_reach", reach_cfg, rd);
  endtask

  task automatic run_walks(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if (!walk_live && $urandom_range(0, 9) == 0) begin
        send_item(REQ_ANSWER, answer_item(1'($urandom_range(0, 1))));
      end else if (!walk_live || $urandom_range(0, 24) == 0) begin
        send_item(REQ_START, rand_start());
        sent++;
      end else begin
        send_item(REQ_ANSWER, answer_item($urandom_range(0, 9) == 0));
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_item(REQ_ANSWER, answer_item(1'b0));
    send_item(REQ_ANSWER, answer_item(1'b1));
    send_item(REQ_START, start_item('0, '0, '0, 16'h4000, '0, '0));
    send_item(REQ_ANSWER, answer_item(1'b0));
    send_item(REQ_ANSWER, answer_item(1'b1));
    send_item(REQ_START, start_item(32'h0000_1800, 32'hFFFF_F800, 32'h0000_07FF,
                                    16'hC000, 16'd9000, 16'hEC78));
    repeat (3) send_item(REQ_ANSWER, answer_item(1'b0));
    // A ray with no direction ties on all axes and leaves the reach at once.
    send_item(REQ_START, start_item('0, '0, '0, '0, '0, '0));
    send_item(REQ_ANSWER, answer_item(1'b0));
    send_item(REQ_START, start_item('0, '0, '0, 16'd9459, 16'd9459, 16'd9459));
    repeat (2) send_item(REQ_ANSWER, answer_item(1'b0));
    // Cell indices wrap at both ends of the grid.
    send_item(REQ_START, start_item(32'h7FFF_FFFF, '0, '0, 16'h4000, '0, '0));
    repeat (2) send_item(REQ_ANSWER, answer_item(1'b0));
    send_item(REQ_ANSWER, answer_item(1'b1));
    send_item(REQ_START, start_item(32'h8000_0000, '0, '0, 16'h8000, '0, '0));
    send_item(REQ_ANSWER, answer_item(1'b0));
    // A start abandons the ray in flight.
    send_item(REQ_START, rand_start());
    send_item(REQ_ANSWER, answer_item(1'b0));
    send_item(REQ_START, rand_start());
    send_item(REQ_ANSWER, answer_item(1'b1));
    settle();
  endtask

  task automatic test_reach_extremes();
    logic [31:0] reaches [5];
    reaches = '{32'd0, 32'd1, CROSS_SAT, $urandom(), MAX_REACH_RST};
    foreach (reaches[i]) begin
      program_reach(reaches[i]);
      run_walks(30);
      settle();
    end
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_req = 300;
    run_walks(30);
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_walks();
    for (int p = 0; p < 4; p++) begin
      program_reach($urandom_range(32'h8000, 32'h18_0000));
      no_idle = (p == 2);
      run_walks(70);
      settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int run;
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    ray_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none got tdata %h status %h",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_x", 32'(want.cell_x), 32'(m_axis_tdata_o[0 +: CELL_OUT_W]));
        check_field("cell_y", 32'(want.cell_y), 32'(m_axis_tdata_o[CELL_OUT_W +: CELL_OUT_W]));
        check_field("cell_z", 32'(want.cell_z),
                    32'(m_axis_tdata_o[2*CELL_OUT_W +: CELL_OUT_W]));
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (psel_i && penable_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb_voxel_ray_traversal: errors");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reach_extremes();
    test_backpressure();
    test_random_walks();
    settle();
    if (fault_count == 0) begin
      $display("tb_voxel_ray_traversal: clean");
    end else begin
      $display("tb_voxel_ray_traversal: errors");
    end
    $finish;
  end

endmodule
